[design/assert_macros.svh]
// Assertion macros for the ray/disk intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define RDI_NEVER(label, cond, msg) \
  `RDI_ASSERT(label, !(cond), msg)

`endif

[design/rdi_pkg.sv]
// Shared types and constants for the ray/disk intersection pipeline.
`default_nettype none

package rdi_pkg;

  // result codes
  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_BEHIND   = 2'd2,
    OUT_OUTSIDE  = 2'd3
  } outcome_e;

  // register indexes
  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_NORMAL_X = 3'd3;
  localparam logic [2:0] CFG_NORMAL_Y = 3'd4;
  localparam logic [2:0] CFG_NORMAL_Z = 3'd5;
  localparam logic [2:0] CFG_RADIUS   = 3'd6;

  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = 31;               // quotient / distance bits
  localparam int NUM_BITS  = 53;               // |num| bits
  localparam int DEN_BITS  = 38;               // |den| bits
  localparam int REM_BITS  = NUM_BITS + FRAC_BITS;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [2:0][31:0] center;
    logic [2:0][17:0] normal;
    logic [30:0]      radius;
  } cfg_t;

  // one incoming ray
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][17:0] dir;
  } ray_t;

  // geometry carried down the pipe: center minus origin, and direction
  typedef struct packed {
    logic [2:0][32:0] co;
    logic [2:0][17:0] dir;
  } geom_t;

  // dot product stage result
  typedef struct packed {
    geom_t                geom;
    logic                 early;   // outcome already settled
    outcome_e             code;
    logic [NUM_BITS-1:0]  num_mag;
    logic [DEN_BITS-1:0]  den_mag;
  } dot_item_t;

  // divider result
  typedef struct packed {
    geom_t               geom;
    logic                early;
    outcome_e            code;
    logic [Q_BITS-1:0]   t;
  } tq_item_t;

endpackage

`default_nettype wire

[design/rdi_dot.sv]
// Front end: center offset, plane dot products and early classification.
`default_nettype none

module rdi_dot (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rdi_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rdi_pkg::ray_t     ray_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rdi_pkg::dot_item_t     item_o
);

  logic [3:0] v_q;
  logic [4:0] rdy;

  // stage 1: center minus origin
  rdi_pkg::geom_t s1_d, s1_q;
  // stage 2: products
  logic [2:0][35:0] pden_d, pden_q;
  logic [2:0][50:0] pnum_d, pnum_q;
  rdi_pkg::geom_t   s2_q;
  // stage 3: sums
  logic signed [37:0] den_d, den_q;
  logic signed [52:0] num_d, num_q;
  rdi_pkg::geom_t     s3_q;
  // stage 4: classification
  rdi_pkg::dot_item_t s4_d, s4_q;

  // ready ripples back, an empty stage always takes
  always_comb begin
    rdy[4] = out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d.co[i]  = $signed({cfg_i.center[i][31], cfg_i.center[i]})
                  - $signed({ray_i.org[i][31], ray_i.org[i]});
      s1_d.dir[i] = ray_i.dir[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pden_d[i] = 36'($signed(s1_q.dir[i]) * $signed(cfg_i.normal[i]));
      pnum_d[i] = 51'($signed(s1_q.co[i]) * $signed(cfg_i.normal[i]));
    end
  end

  assign den_d = 38'($signed(pden_q[0])) + 38'($signed(pden_q[1]))
               + 38'($signed(pden_q[2]));
  assign num_d = 53'($signed(pnum_q[0])) + 53'($signed(pnum_q[1]))
               + 53'($signed(pnum_q[2]));

  // parallel beats behind
  always_comb begin
    s4_d.geom    = s3_q;
    s4_d.den_mag = den_q[37] ? 38'(-den_q) : 38'(den_q);
    s4_d.num_mag = num_q[52] ? 53'(-num_q) : 53'(num_q);
    s4_d.early   = 1'b1;
    s4_d.code    = rdi_pkg::OUT_HIT;
    if (den_q == '0) begin
      s4_d.code = rdi_pkg::OUT_PARALLEL;
    end else if (num_q == '0 || (num_q[52] != den_q[37])) begin
      s4_d.code = rdi_pkg::OUT_BEHIND;
    end else begin
      s4_d.early = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) s1_q <= s1_d;
    if (rdy[1]) begin
      pden_q <= pden_d;
      pnum_q <= pnum_d;
      s2_q   <= s1_q;
    end
    if (rdy[2]) begin
      den_q <= den_d;
      num_q <= num_d;
      s3_q  <= s2_q;
    end
    if (rdy[3]) s4_q <= s4_d;
  end

  assign out_valid_o = v_q[3];
  assign item_o      = s4_q;

endmodule

`default_nettype wire

[design/rdi_div.sv]
// Pipelined restoring divider: t = min(|num| * 2^F / |den|, max), one bit a stage.
`default_nettype none

module rdi_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rdi_pkg::dot_item_t item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rdi_pkg::tq_item_t       item_o
);

  localparam int QB  = rdi_pkg::Q_BITS;
  localparam int RB  = rdi_pkg::REM_BITS;
  localparam int DB  = rdi_pkg::DEN_BITS;
  localparam int NST = QB + 1;

  typedef struct packed {
    rdi_pkg::geom_t    geom;
    logic              early;
    rdi_pkg::outcome_e code;
    logic              sat;
    logic [RB-1:0]     rem;
    logic [DB-1:0]     den;
    logic [QB-1:0]     q;
  } div_stage_t;

  div_stage_t       stg_d [NST];
  div_stage_t       stg_q [NST];
  logic [NST-1:0]   v_q;
  logic [NST:0]     rdy;

  assign rdy[NST] = out_ready_i;
  assign in_ready_o = rdy[0];

  // first stage: dividend alignment and overflow check
  always_comb begin
    stg_d[0].geom  = item_i.geom;
    stg_d[0].early = item_i.early;
    stg_d[0].code  = item_i.code;
    stg_d[0].rem   = {item_i.num_mag, {rdi_pkg::FRAC_BITS{1'b0}}};
    stg_d[0].den   = item_i.den_mag;
    stg_d[0].q     = '0;
    stg_d[0].sat   = ({item_i.num_mag, {rdi_pkg::FRAC_BITS{1'b0}}}
                      >= RB'({item_i.den_mag, {QB{1'b0}}}));
  end

  for (genvar j = 0; j < NST; j++) begin : g_stage
    assign rdy[j] = !v_q[j] || rdy[j+1];

    // one quotient bit per stage, MSB first
    if (j > 0) begin : g_bit
      localparam int K = QB - j;
      logic [RB-1:0] shd;
      logic          ge;
      assign shd = RB'({{(RB-DB){1'b0}}, stg_q[j-1].den} << K);
      assign ge  = stg_q[j-1].rem >= shd;
      always_comb begin
        stg_d[j]      = stg_q[j-1];
        stg_d[j].q[K] = ge;
        stg_d[j].rem  = ge ? (stg_q[j-1].rem - shd) : stg_q[j-1].rem;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= (j == 0) ? in_valid_i : v_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) stg_q[j] <= stg_d[j];
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign item_o.geom  = stg_q[NST-1].geom;
  assign item_o.early = stg_q[NST-1].early;
  assign item_o.code  = stg_q[NST-1].code;
  assign item_o.t     = stg_q[NST-1].sat ? {QB{1'b1}} : stg_q[NST-1].q;

endmodule

`default_nettype wire

[design/rdi_bound.sv]
// Back end: hit point offset, radius test and result register.
`default_nettype none

module rdi_bound (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rdi_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rdi_pkg::tq_item_t item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rdi_pkg::outcome_e      outcome_o,
  output logic [30:0]            distance_o
);

  logic [4:0] v_q;
  logic [5:0] rdy;

  // settled-code bookkeeping carried along
  typedef struct packed {
    logic              done;
    rdi_pkg::outcome_e code;
    logic [30:0]       t;
  } res_t;

  res_t               r1_d, r1_q, r2_q, r3_d, r3_q, r4_q;
  logic [2:0][49:0]   dt_d, dt_q;
  logic [2:0][32:0]   co1_q, co2_q;
  logic [2:0][34:0]   dr_d, dr_q;
  logic [2:0][30:0]   m_d, m_q;
  logic [2:0][61:0]   sq_d, sq_q;
  logic [61:0]        rsq_d, rsq_q;
  logic [63:0]        sum;
  rdi_pkg::outcome_e  code_d, code_q;
  logic [30:0]        dist_d, dist_q;

  always_comb begin
    rdy[5] = out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  // stage 1: dir * t, zero t is behind
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dt_d[i] = 50'($signed(item_i.geom.dir[i]) * $signed({1'b0, item_i.t}));
    end
    r1_d.t    = item_i.t;
    r1_d.done = item_i.early || (item_i.t == '0);
    r1_d.code = item_i.early ? item_i.code : rdi_pkg::OUT_BEHIND;
  end

  // stage 2: drop fraction toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [49:0] pm;
      logic [33:0] sh;
      pm = dt_q[i][49] ? 50'(-$signed(dt_q[i])) : dt_q[i];
      sh = pm[49:rdi_pkg::FRAC_BITS];
      dr_d[i] = dt_q[i][49] ? 35'(-$signed({1'b0, sh})) : {1'b0, sh};
    end
  end

  // stage 3: offset from center and per-axis bound
  always_comb begin
    r3_d = r2_q;
    for (int i = 0; i < 3; i++) begin
      logic signed [35:0] off;
      logic [35:0]        om;
      off = 36'($signed(dr_q[i])) - 36'($signed(co2_q[i]));
      om  = off[35] ? 36'(-off) : 36'(off);
      m_d[i] = om[30:0];
      if (!r2_q.done && (om > {5'b0, cfg_i.radius})) begin
        r3_d.done = 1'b1;
        r3_d.code = rdi_pkg::OUT_OUTSIDE;
      end
    end
  end

  // stage 4: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = m_q[i] * m_q[i];
    end
    rsq_d = cfg_i.radius * cfg_i.radius;
  end

  // stage 5: squared length against squared radius
  assign sum = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
  always_comb begin
    code_d = r4_q.code;
    if (!r4_q.done) begin
      code_d = (sum > {2'b0, rsq_q}) ? rdi_pkg::OUT_OUTSIDE : rdi_pkg::OUT_HIT;
    end
    dist_d = (code_d == rdi_pkg::OUT_HIT) ? r4_q.t : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dt_q  <= dt_d;
      co1_q <= item_i.geom.co;
      r1_q  <= r1_d;
    end
    if (rdy[1]) begin
      dr_q  <= dr_d;
      co2_q <= co1_q;
      r2_q  <= r1_q;
    end
    if (rdy[2]) begin
      m_q  <= m_d;
      r3_q <= r3_d;
    end
    if (rdy[3]) begin
      sq_q  <= sq_d;
      rsq_q <= rsq_d;
      r4_q  <= r3_q;
    end
    if (rdy[4]) begin
      code_q <= code_d;
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = v_q[4];
  assign outcome_o   = code_q;
  assign distance_o  = dist_q;

endmodule

`default_nettype wire

[design/ray_disk_intersect_top.sv]
// Top level of the ray/disk intersection pipeline with its register file.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | origin_x/y/z_i, dir_x/y/z_i
//  out     | source    | out_valid_o/out_stall_i| outcome_o, distance_o
//  cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One ray per cycle while out_stall_i is low; 4 dot-product stages,
// 32 divider stages (overflow check plus one quotient bit each), 5 bound stages.
// Every stage has its own valid bit; an empty stage loads even while later ones
// stall, so bubbles are squeezed out. Reset clears the valid bits and loads the disk
// registers with their defaults; datapath registers are not reset.
`default_nettype none

module ray_disk_intersect_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic signed [31:0] origin_z_i,
  input  wire logic signed [17:0] dir_x_i,
  input  wire logic signed [17:0] dir_y_i,
  input  wire logic signed [17:0] dir_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              outcome_o,
  output logic [30:0]             distance_o
);

  `include "assert_macros.svh"

  rdi_pkg::cfg_t      cfg_q;
  rdi_pkg::ray_t      ray;
  rdi_pkg::dot_item_t dot_item;
  rdi_pkg::tq_item_t  tq_item;
  rdi_pkg::outcome_e  outcome;
  logic               in_ready, dot_valid, div_ready, div_valid, bnd_ready;
  logic               is_hit;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center <= '0;
      cfg_q.normal <= {18'd65536, 18'd0, 18'd0};
      cfg_q.radius <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rdi_pkg::CFG_CENTER_X: cfg_q.center[0] <= cfg_wdata_i;
        rdi_pkg::CFG_CENTER_Y: cfg_q.center[1] <= cfg_wdata_i;
        rdi_pkg::CFG_CENTER_Z: cfg_q.center[2] <= cfg_wdata_i;
        rdi_pkg::CFG_NORMAL_X: cfg_q.normal[0] <= cfg_wdata_i[17:0];
        rdi_pkg::CFG_NORMAL_Y: cfg_q.normal[1] <= cfg_wdata_i[17:0];
        rdi_pkg::CFG_NORMAL_Z: cfg_q.normal[2] <= cfg_wdata_i[17:0];
        rdi_pkg::CFG_RADIUS:   cfg_q.radius    <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign ray.org = {origin_z_i, origin_y_i, origin_x_i};
  assign ray.dir = {dir_z_i, dir_y_i, dir_x_i};

  rdi_dot u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .ray_i       (ray),
    .out_valid_o (dot_valid),
    .out_ready_i (div_ready),
    .item_o      (dot_item)
  );

  rdi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dot_valid),
    .in_ready_o  (div_ready),
    .item_i      (dot_item),
    .out_valid_o (div_valid),
    .out_ready_i (bnd_ready),
    .item_o      (tq_item)
  );

  rdi_bound u_bound (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (bnd_ready),
    .item_i      (tq_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .outcome_o   (outcome),
    .distance_o  (distance_o)
  );

  assign in_stall_o = !in_ready;
  assign outcome_o  = outcome;
  assign is_hit     = (outcome == rdi_pkg::OUT_HIT);

  // distance only rides on a hit, and a hit never has zero distance
  `RDI_NEVER(a_miss_dist, out_valid_o && !is_hit && (distance_o != '0), "distance on miss")
  `RDI_NEVER(a_hit_zero, out_valid_o && is_hit && (distance_o == '0), "hit with zero t")
  // an empty output stage means the whole pipe can move
  `RDI_ASSERT(a_no_stall, !out_valid_o |-> !in_stall_o, "stall with empty output")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the ray/disk intersection pipeline.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY   = 41;
  localparam int WDOG_MAX  = 20000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [1:0]  outcome;
    logic [30:0] distance;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [17:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [30:0] distance_o;

  ray_disk_intersect_top DUT (.*);

  // shadow copy of the disk registers
  logic signed [31:0] disk_center [3];
  logic signed [17:0] disk_normal [3];
  logic [30:0]        disk_radius;

  hit_t expected_hits[$];
  int   mismatches = 0;
  int   rays_sent = 0;
  int   hits_checked = 0;
  int   outcome_seen [4] = '{0, 0, 0, 0};
  int   idle_cycles = 0;
  bit   sink_idle_en = 1'b0;
  bit   src_idle_en = 1'b0;
  int   hold_off = 0;

  initial forever #6 clk_i = ~clk_i;

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // intersection of one ray with the configured disk
  function automatic hit_t intersect_disk(input logic signed [31:0] org [3],
                                          input logic signed [17:0] dir [3]);
    hit_t r;
    logic signed [63:0] num, den, ofs [3], p;
    logic [63:0] nm, dm, q, rem, t, lim, sum, a;
    num = 0;
    den = 0;
    sum = 0;
    r.outcome = rdi_pkg::OUT_HIT;
    r.distance = '0;
    for (int i = 0; i < 3; i++) begin
      den += 64'(dir[i]) * 64'(disk_normal[i]);
      num += (64'(disk_center[i]) - 64'(org[i])) * 64'(disk_normal[i]);
    end
    if (den == 0) begin
      r.outcome = rdi_pkg::OUT_PARALLEL;
      return r;
    end
    if (num == 0 || ((num < 0) != (den < 0))) begin
      r.outcome = rdi_pkg::OUT_BEHIND;
      return r;
    end
    // truncated quotient in Q15.16, saturated
    nm = abs64(num);
    dm = abs64(den);
    lim = 64'h7FFF_FFFF;
    q = nm / dm;
    rem = nm % dm;
    if (q > (lim >> rdi_pkg::FRAC_BITS)) t = lim;
    else begin
      t = (q << rdi_pkg::FRAC_BITS) | ((rem << rdi_pkg::FRAC_BITS) / dm);
      if (t > lim) t = lim;
    end
    if (t == 0) begin
      r.outcome = rdi_pkg::OUT_BEHIND;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      p = 64'(dir[i]) * $signed(t);
      a = abs64(p) >> rdi_pkg::FRAC_BITS;
      ofs[i] = 64'(org[i]) - 64'(disk_center[i]) + (p < 0 ? -$signed(a) : $signed(a));
      if (abs64(ofs[i]) > 64'(disk_radius)) begin
        r.outcome = rdi_pkg::OUT_OUTSIDE;
        return r;
      end
    end
    for (int i = 0; i < 3; i++) sum += abs64(ofs[i]) * abs64(ofs[i]);
    if (sum > 64'(disk_radius) * 64'(disk_radius)) begin
      r.outcome = rdi_pkg::OUT_OUTSIDE;
      return r;
    end
    r.distance = t[30:0];
    return r;
  endfunction

  // register write, testbench side only while the pipe is drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rdi_pkg::CFG_CENTER_X: disk_center[0] = val;
      rdi_pkg::CFG_CENTER_Y: disk_center[1] = val;
      rdi_pkg::CFG_CENTER_Z: disk_center[2] = val;
      rdi_pkg::CFG_NORMAL_X: disk_normal[0] = val[17:0];
      rdi_pkg::CFG_NORMAL_Y: disk_normal[1] = val[17:0];
      rdi_pkg::CFG_NORMAL_Z: disk_normal[2] = val[17:0];
      rdi_pkg::CFG_RADIUS:   disk_radius = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_disk(input logic signed [31:0] cx, cy, cz,
                          input logic signed [17:0] nx, ny, nz,
                          input logic [30:0] rad);
    write_reg(rdi_pkg::CFG_CENTER_X, cx);
    write_reg(rdi_pkg::CFG_CENTER_Y, cy);
    write_reg(rdi_pkg::CFG_CENTER_Z, cz);
    write_reg(rdi_pkg::CFG_NORMAL_X, 32'(nx));
    write_reg(rdi_pkg::CFG_NORMAL_Y, 32'(ny));
    write_reg(rdi_pkg::CFG_NORMAL_Z, 32'(nz));
    write_reg(rdi_pkg::CFG_RADIUS, 32'(rad));
  endtask

  // send one ray; the prediction is queued at acceptance, valid stays up
  task automatic send_ray(input logic signed [31:0] ox, oy, oz,
                          input logic signed [17:0] dx, dy, dz);
    logic signed [31:0] org [3];
    logic signed [17:0] dir [3];
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
    while (src_idle_en && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox; origin_y_i <= oy; origin_z_i <= oz;
    dir_x_i <= dx; dir_y_i <= dy; dir_z_i <= dz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_hits = {expected_hits, intersect_disk(org, dir)};
    rays_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [17:0] rand_dir;
    case ($urandom_range(5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'(-$signed(18'($urandom_range(65536))));
      3: return 18'($urandom);
      default: return 18'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
    endcase
  endfunction

  // directed cases: the named special cases with the reset disk
  task automatic test_directed;
    send_ray(0, 0, 65536, 0, 0, -65536);                // hit at t = 1
    send_ray(0, 0, 65536, 65536, 0, 0);                 // parallel
    send_ray(0, 0, 65536, 0, 0, 65536);                 // behind, opposite sign
    send_ray(0, 0, 0, 0, 0, 65536);                     // behind, origin on plane
    send_ray(0, 0, 1, 0, 0, -18'sd131071);              // behind, t under one LSB
    send_ray(32'sh7FFF_FFFF, 0, 65536, 0, 0, -65536);   // outside, x offset
    send_ray(65536, 0, 65536, 0, 0, -65536);            // on the rim: hit
    send_ray(46341, 46341, 65536, 0, 0, -65536);        // outside by squared length
    send_ray(0, 0, 32'sh7FFF_FFFF, 0, 0, -1);           // far plane, saturated t
    send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             18'sh20000, 18'sd131071, -18'sd1);
    send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
             18'sd131071, 18'sh20000, 18'sd131071);
    send_ray(0, 0, -65536, 0, 0, 65536);
    send_ray(-32768, 32768, 131072, 16384, -16384, -65536);
    drain();
  endtask

  // random rays against several disk settings, extremes included
  task automatic test_random_disks;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_disk(0, 0, 0, 0, 0, 65536, 31'h7FFF_FFFF);
        1: set_disk(0, 0, 0, 65536, 0, 0, 0);
        2: set_disk(32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                    18'sh20000, 18'sd131071, 18'sd1, 31'h4000_0000);
        3: set_disk(rand_coord(), rand_coord(), rand_coord(),
                    46341, 0, -46341, 3 << 16);
        default: set_disk(rand_coord(), rand_coord(), rand_coord(),
                          rand_dir(), rand_dir(), rand_dir(), $urandom_range(8 << 16));
      endcase
      src_idle_en = (phase != 1);
      sink_idle_en = (phase != 1);
      for (int k = 0; k < 65; k++)
        send_ray(rand_coord(), rand_coord(), rand_coord(),
                 rand_dir(), rand_dir(), rand_dir());
      drain();
    end
  endtask

  // receiver holds off long enough for the pipe to fill and stall
  task automatic test_backpressure;
    set_disk(0, 0, 0, 0, 0, 65536, 1 << 20);
    hold_off = 150;
    for (int k = 0; k < 60; k++)
      send_ray(rand_coord(), rand_coord(), 32'($urandom_range(8 << 16)),
               rand_dir(), rand_dir(), -18'($urandom_range(65536)));
    drain();
  endtask

  // receiver stall: random, or a long counted hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= sink_idle_en && ($urandom_range(99) < 20);
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    hit_t exp_hit;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: outcome %0d distance %0d", outcome_o, distance_o);
      end else begin
        exp_hit = expected_hits.pop_front();
        hits_checked++;
        outcome_seen[outcome_o]++;
        if (outcome_o !== exp_hit.outcome || distance_o !== exp_hit.distance) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: expected outcome %0d distance %0d, got %0d %0d",
                     hits_checked, exp_hit.outcome, exp_hit.distance,
                     outcome_o, distance_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    disk_center = '{0, 0, 0};
    disk_normal = '{0, 0, 65536};
    disk_radius = 65536;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    sink_idle_en = 1'b1;
    test_random_disks();
    sink_idle_en = 1'b1;
    test_backpressure();
    write_reg(3'd7, 32'hFFFF_FFFF);  // unused index, must be ignored
    for (int k = 0; k < 12; k++)
      send_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
    drain();
    $display("%0d rays sent, %0d results checked against several disk settings",
             rays_sent, hits_checked);
    $display("outcomes: hit %0d, parallel %0d, behind %0d, outside %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
